// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALW(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/sto_pkg.sv =====
// ----------------------------------------------------------------------------
// sto_pkg
// Types and constants of the sorted timer queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sto_pkg;

  localparam int MAX_FIRES  = 16;
  localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_OK    = 2'd0,
    KIND_ERROR = 2'd1,
    KIND_FIRED = 2'd2,
    KIND_IDLE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    MODE_HOLD   = 3'd0,
    MODE_CLEAR  = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_CANCEL = 3'd3,
    MODE_POP    = 3'd4
  } mode_t;

  typedef struct packed {
    logic [31:0] handle;
    logic [63:0] expiry;
    logic [31:0] period;
    logic [15:0] remain;
  } entry_t;

  typedef struct packed {
    mode_t  mode;
    entry_t data;
  } chain_cmd_t;

  typedef struct packed {
    logic   head_valid;
    entry_t head;
    logic   full;
  } chain_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sto_cell.sv =====
// ----------------------------------------------------------------------------
// sto_cell
// One queue slot: holds an entry and trades it with its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sto_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sto_pkg::chain_cmd_t cmd,
  input  wire logic               left_valid,
  input  wire sto_pkg::entry_t    left_entry,
  input  wire logic               left_shift,
  input  wire logic               left_hit,
  input  wire logic               right_valid,
  input  wire sto_pkg::entry_t    right_entry,
  output logic                    valid,
  output sto_pkg::entry_t         entry,
  output logic                    shift,
  output logic                    hit
);

  assign shift = !valid || (entry.expiry > cmd.data.expiry);
  assign hit   = left_hit || (valid && (entry.handle == cmd.data.handle));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd.mode)
        sto_pkg::MODE_CLEAR: begin
          valid <= 1'b0;
        end
        sto_pkg::MODE_INSERT: begin
          if (left_shift) begin
            valid <= left_valid;
            entry <= left_entry;
          end else if (shift) begin
            valid <= 1'b1;
            entry <= cmd.data;
          end
        end
        sto_pkg::MODE_CANCEL: begin
          if (hit) begin
            valid <= right_valid;
            entry <= right_entry;
          end
        end
        sto_pkg::MODE_POP: begin
          valid <= right_valid;
          entry <= right_entry;
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_RST(a_valid_prefix, clk, rst, valid |-> left_valid, "hole in queue")
  `ASSERT_RST(a_sorted, clk, rst, valid |-> left_entry.expiry <= entry.expiry, "queue unsorted")
  `ASSERT_RST(a_no_handle_zero, clk, rst, valid |-> entry.handle != 32'd0, "zero handle queued")

endmodule

`default_nettype wire

// ===== rtl/sto_chain.sv =====
// ----------------------------------------------------------------------------
// sto_chain
// Row of queue cells kept in expiry order, head at cell zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sto_chain #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sto_pkg::chain_cmd_t cmd,
  output sto_pkg::chain_stat_t     stat
);

  logic            cell_valid [QUEUE_DEPTH];
  sto_pkg::entry_t cell_entry [QUEUE_DEPTH];
  logic            cell_shift [QUEUE_DEPTH];
  logic            cell_hit   [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic            lv;
    sto_pkg::entry_t le;
    logic            ls;
    logic            lh;
    logic            rv;
    sto_pkg::entry_t re;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign le = '0;
      assign ls = 1'b0;
      assign lh = 1'b0;
    end else begin : g_mid
      assign lv = cell_valid[i-1];
      assign le = cell_entry[i-1];
      assign ls = cell_shift[i-1];
      assign lh = cell_hit[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign rv = 1'b0;
      assign re = '0;
    end else begin : g_body
      assign rv = cell_valid[i+1];
      assign re = cell_entry[i+1];
    end

    sto_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_valid  (lv),
      .left_entry  (le),
      .left_shift  (ls),
      .left_hit    (lh),
      .right_valid (rv),
      .right_entry (re),
      .valid       (cell_valid[i]),
      .entry       (cell_entry[i]),
      .shift       (cell_shift[i]),
      .hit         (cell_hit[i])
    );
  end

  assign stat.head_valid = cell_valid[0];
  assign stat.head       = cell_entry[0];
  assign stat.full       = cell_valid[QUEUE_DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Timer queue sorted by expiry, with a saturating tick counter.
// ----------------------------------------------------------------------------
// A command is transferred when start is high and busy is low: opcode picks
// clear, start timer, cancel timer or tick, with timer_handle, interval_ticks
// and repeat_count as operands. Results come out on result_kind,
// fired_handle and last, each marked by a one-cycle strobe; the receiver
// must take every strobe, there is no backpressure.
// Clear, start and cancel finish in the transfer cycle: the single result
// strobes on the next cycle and busy stays low, so one of these can be
// transferred every cycle. The queue is a row of cells that insert, cancel
// or pop with all cells acting at once.
// A tick advances time and checks the head; each due timer is popped from
// the head and, if it still repeats, re-armed into the row before the next
// check; up to 16 timers fire per tick. Busy is high for the whole tick. Each
// fired result strobes once the next head is checked, so last is exact.
// Reset empties the queue, sets time to zero and idles the controller; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sorted_timer_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] timer_handle,
  input  wire logic [31:0] interval_ticks,
  input  wire logic [15:0] repeat_count,
  output logic             strobe,
  output logic [1:0]       result_kind,
  output logic [31:0]      fired_handle,
  output logic             last
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_REARM = 3'b100
  } state_t;

  state_t                           state;
  logic [63:0]                      now;
  logic [sto_pkg::FIRE_CNT_W-1:0]   fire_cnt;
  logic                             pend;
  logic [31:0]                      fire_handle;
  logic [31:0]                      fire_period;
  logic [15:0]                      fire_remain;
  logic                             fire_keep;

  sto_pkg::chain_cmd_t  cmd;
  sto_pkg::chain_stat_t stat;

  logic        accept;
  logic [63:0] now_next;
  logic [64:0] start_sum;
  logic [63:0] start_exp;
  logic [64:0] rearm_sum;
  logic [63:0] rearm_exp;
  logic        start_err;
  logic        head_due;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign now_next  = (now == '1) ? now : now + 64'd1;
  assign start_sum = {1'b0, now} + {33'd0, interval_ticks};
  assign start_exp = start_sum[64] ? '1 : start_sum[63:0];
  assign rearm_sum = {1'b0, now} + {33'd0, fire_period};
  assign rearm_exp = rearm_sum[64] ? '1 : rearm_sum[63:0];
  assign start_err = (timer_handle == 32'd0) || (interval_ticks == 32'd0) || stat.full;
  assign head_due  = stat.head_valid && (stat.head.expiry <= now)
                   && (fire_cnt < sto_pkg::FIRE_CNT_W'(sto_pkg::MAX_FIRES));

  always_comb begin
    cmd.mode        = sto_pkg::MODE_HOLD;
    cmd.data.handle = timer_handle;
    cmd.data.expiry = start_exp;
    cmd.data.period = interval_ticks;
    cmd.data.remain = repeat_count;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (sto_pkg::op_t'(opcode))
            sto_pkg::OP_CLEAR:  cmd.mode = sto_pkg::MODE_CLEAR;
            sto_pkg::OP_START:  cmd.mode = start_err ? sto_pkg::MODE_HOLD
                                                     : sto_pkg::MODE_INSERT;
            sto_pkg::OP_CANCEL: cmd.mode = sto_pkg::MODE_CANCEL;
            default:            cmd.mode = sto_pkg::MODE_HOLD;
          endcase
        end
      end
      S_CHECK: begin
        if (head_due) begin
          cmd.mode = sto_pkg::MODE_POP;
        end
      end
      S_REARM: begin
        cmd.data.handle = fire_handle;
        cmd.data.expiry = rearm_exp;
        cmd.data.period = fire_period;
        cmd.data.remain = fire_remain;
        if (fire_keep) begin
          cmd.mode = sto_pkg::MODE_INSERT;
        end
      end
      default: begin
      end
    endcase
  end

  sto_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      strobe   <= 1'b0;
      now      <= '0;
      fire_cnt <= '0;
      pend     <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (sto_pkg::op_t'(opcode))
              sto_pkg::OP_TICK: begin
                now      <= now_next;
                fire_cnt <= '0;
                pend     <= 1'b0;
                state    <= S_CHECK;
              end
              sto_pkg::OP_START: begin
                strobe       <= 1'b1;
                result_kind  <= start_err ? sto_pkg::KIND_ERROR : sto_pkg::KIND_OK;
                fired_handle <= '0;
                last         <= 1'b1;
              end
              default: begin
                strobe       <= 1'b1;
                result_kind  <= sto_pkg::KIND_OK;
                fired_handle <= '0;
                last         <= 1'b1;
              end
            endcase
          end
        end
        S_CHECK: begin
          if (head_due) begin
            if (pend) begin
              strobe       <= 1'b1;
              result_kind  <= sto_pkg::KIND_FIRED;
              fired_handle <= fire_handle;
              last         <= 1'b0;
            end
            fire_handle <= stat.head.handle;
            fire_period <= stat.head.period;
            fire_remain <= stat.head.remain - {15'd0, (stat.head.remain != 16'd0)};
            fire_keep   <= (stat.head.remain != 16'd1) && (stat.head.period != 32'd0)
                         && (now != '1);
            fire_cnt    <= fire_cnt + 1'b1;
            pend        <= 1'b1;
            state       <= S_REARM;
          end else begin
            strobe       <= 1'b1;
            result_kind  <= pend ? sto_pkg::KIND_FIRED : sto_pkg::KIND_IDLE;
            fired_handle <= pend ? fire_handle : 32'd0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        S_REARM: begin
          state <= S_CHECK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_RST(a_last_idle, clk, rst, strobe && last |-> state == S_IDLE, "last while busy")
  `ASSERT_RST(a_more_rearm, clk, rst, strobe && !last |-> state == S_REARM, "stray result")
  `ASSERT_RST(a_rearm_check, clk, rst, state == S_REARM |=> state == S_CHECK, "rearm stuck")
  `ASSERT_RST(a_fire_bound, clk, rst, busy |-> fire_cnt <= sto_pkg::FIRE_CNT_W'(sto_pkg::MAX_FIRES), "too many fires")

endmodule

`default_nettype wire

// ===== test/tb_sorted_timer_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_timer_queue
// Self-checking bench for the sorted timer queue. A directed table walks
// the error cases, duplicate handles, one-shot and repeating timers; a loop
// then fills the queue, overflows it and fires every entry in one tick.
// Random commands follow. Every transfer goes through a local queue
// predictor; each strobed result is compared with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_sorted_timer_queue;
  import sto_pkg::*;

  localparam int QUEUE_DEPTH   = 16;
  localparam int RANDOM_ITEMS  = 330;
  localparam int STALL_LIMIT   = 1000;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] handle;
    logic        last_flag;
  } timer_result_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] handle;
    logic [31:0] interval;
    logic [15:0] count;
    logic        typed;
    kind_t       kind;
    logic [31:0] fired;
  } command_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  opcode;
  logic [31:0] timer_handle;
  logic [31:0] interval_ticks;
  logic [15:0] repeat_count;
  logic        strobe;
  logic [1:0]  result_kind;
  logic [31:0] fired_handle;
  logic        last;

  logic        cmd_typed;
  kind_t       cmd_kind;
  logic [31:0] cmd_fired;

  logic [63:0]   tick_now;
  entry_t        timers [QUEUE_DEPTH];
  int            timer_count;
  timer_result_t expected_results [$];
  int            error_count;
  int            quiet_cycles;

  command_row_t directed_rows [14] = '{
    '{OP_TICK,   32'd0,         32'd0,         16'd0,      1'b1, KIND_IDLE,  32'd0},
    '{OP_START,  32'd0,         32'd5,         16'd1,      1'b1, KIND_ERROR, 32'd0},
    '{OP_START,  32'd1,         32'd0,         16'd1,      1'b1, KIND_ERROR, 32'd0},
    '{OP_CANCEL, 32'd0,         32'd0,         16'd0,      1'b1, KIND_OK,    32'd0},
    '{OP_START,  32'hFFFF_FFFF, 32'd1,         16'd1,      1'b1, KIND_OK,    32'd0},
    '{OP_TICK,   32'd0,         32'd0,         16'd0,      1'b1, KIND_FIRED, 32'hFFFF_FFFF},
    '{OP_START,  32'd7,         32'd2,         16'd3,      1'b1, KIND_OK,    32'd0},
    '{OP_START,  32'd7,         32'hFFFF_FFFF, 16'd0,      1'b1, KIND_OK,    32'd0},
    '{OP_CANCEL, 32'd7,         32'd0,         16'd0,      1'b1, KIND_OK,    32'd0},
    '{OP_CANCEL, 32'h0000_5A5A, 32'd0,         16'd0,      1'b1, KIND_OK,    32'd0},
    '{OP_START,  32'd8,         32'd2,         16'hFFFF,   1'b1, KIND_OK,    32'd0},
    '{OP_TICK,   32'd0,         32'd0,         16'd0,      1'b1, KIND_IDLE,  32'd0},
    '{OP_TICK,   32'd0,         32'd0,         16'd0,      1'b0, KIND_OK,    32'd0},
    '{OP_CLEAR,  32'd0,         32'd0,         16'd0,      1'b1, KIND_OK,    32'd0}
  };

  sorted_timer_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .timer_handle  (timer_handle),
    .interval_ticks(interval_ticks),
    .repeat_count  (repeat_count),
    .strobe        (strobe),
    .result_kind   (result_kind),
    .fired_handle  (fired_handle),
    .last          (last)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
    logic [64:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[64] ? '1 : sum[63:0];
  endfunction

  task automatic insert_timer(entry_t e);
    int pos;
    int i;
    pos = 0;
    while (pos < timer_count && timers[pos].expiry <= e.expiry) pos++;
    for (i = timer_count; i > pos; i--) timers[i] = timers[i-1];
    timers[pos] = e;
    timer_count++;
  endtask

  task automatic remove_timer(int pos);
    int i;
    for (i = pos; i < timer_count - 1; i++) timers[i] = timers[i+1];
    timer_count--;
  endtask

  task automatic predict_command(op_t op, logic [31:0] h, logic [31:0] iv, logic [15:0] cnt);
    entry_t head;
    int     fires;
    int     i;
    logic   keep;
    case (op)
      OP_CLEAR: begin
        timer_count = 0;
        expected_results.push_back('{KIND_OK, 32'd0, 1'b0});
      end
      OP_START: begin
        if (h == 0 || iv == 0 || timer_count >= QUEUE_DEPTH) begin
          expected_results.push_back('{KIND_ERROR, 32'd0, 1'b0});
        end else begin
          insert_timer('{handle: h, expiry: sat_add64(tick_now, {32'd0, iv}),
                         period: iv, remain: cnt});
          expected_results.push_back('{KIND_OK, 32'd0, 1'b0});
        end
      end
      OP_CANCEL: begin
        keep = 1'b1;
        for (i = 0; i < timer_count && keep; i++) begin
          if (timers[i].handle == h) begin
            remove_timer(i);
            keep = 1'b0;
          end
        end
        expected_results.push_back('{KIND_OK, 32'd0, 1'b0});
      end
      default: begin
        tick_now = sat_add64(tick_now, 64'd1);
        fires = 0;
        while (fires < MAX_FIRES && timer_count > 0 && timers[0].expiry <= tick_now) begin
          head = timers[0];
          remove_timer(0);
          expected_results.push_back('{KIND_FIRED, head.handle, 1'b0});
          fires++;
          keep = 1'b1;
          if (head.remain != 0) begin
            head.remain = head.remain - 16'd1;
            keep = (head.remain != 0);
          end
          // drop a saturated re-arm so it cannot stay due forever
          if (keep && head.period != 0 && tick_now != '1) begin
            head.expiry = sat_add64(tick_now, {32'd0, head.period});
            insert_timer(head);
          end
        end
        if (fires == 0) expected_results.push_back('{KIND_IDLE, 32'd0, 1'b0});
      end
    endcase
    expected_results[expected_results.size()-1].last_flag = 1'b1;
  endtask

  always @(posedge clk) begin
    int            depth_mark;
    timer_result_t got;
    timer_result_t want;
    if (!rst) begin
      if (strobe) begin
        got = '{kind_t'(result_kind), fired_handle, last};
        if (expected_results.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("unexpected result: kind %0d handle %h last %b",
                     result_kind, fired_handle, last);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (error_count < MAX_REPORTS)
              $display("mismatch: expected kind %0d handle %h last %b, got kind %0d handle %h last %b",
                       want.kind, want.handle, want.last_flag,
                       got.kind, got.handle, got.last_flag);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        depth_mark = expected_results.size();
        predict_command(op_t'(opcode), timer_handle, interval_ticks, repeat_count);
        if (cmd_typed) begin
          while (expected_results.size() > depth_mark) void'(expected_results.pop_back());
          expected_results.push_back('{cmd_kind, cmd_fired, 1'b1});
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("tb_sorted_timer_queue: FAIL");
      $finish;
    end
  end

  task automatic issue_command(op_t op, logic [31:0] h, logic [31:0] iv, logic [15:0] cnt,
                               logic typed, kind_t kind, logic [31:0] fired);
    opcode         <= op;
    timer_handle   <= h;
    interval_ticks <= iv;
    repeat_count   <= cnt;
    cmd_typed      <= typed;
    cmd_kind       <= kind;
    cmd_fired      <= fired;
    start          <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic maybe_pause();
    if ($urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    int          n;
    int          roll;
    op_t         op;
    logic [31:0] h;
    logic [31:0] iv;
    logic [15:0] cnt;
    tick_now       = 64'd0;
    timer_count    = 0;
    error_count    = 0;
    quiet_cycles   = 0;
    rst            <= 1'b1;
    start          <= 1'b0;
    opcode         <= OP_CLEAR;
    timer_handle   <= 32'd0;
    interval_ticks <= 32'd0;
    repeat_count   <= 16'd0;
    cmd_typed      <= 1'b0;
    cmd_kind       <= KIND_OK;
    cmd_fired      <= 32'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      maybe_pause();
      issue_command(directed_rows[i].op, directed_rows[i].handle, directed_rows[i].interval,
                    directed_rows[i].count, directed_rows[i].typed, directed_rows[i].kind,
                    directed_rows[i].fired);
    end

    // fill the queue, overflow it, then fire every entry in one tick
    for (n = 0; n < QUEUE_DEPTH; n++) begin
      maybe_pause();
      issue_command(OP_START, 32'h100 + n, 32'd1, 16'(n % 3), 1'b1, KIND_OK, 32'd0);
    end
    issue_command(OP_START, 32'h0000_ABCD, 32'd1, 16'd1, 1'b1, KIND_ERROR, 32'd0);
    issue_command(OP_TICK, 32'd0, 32'd0, 16'd0, 1'b0, KIND_OK, 32'd0);
    drain_results();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n < 150 || n >= 230) maybe_pause();
      if (n == 100 || n == 260) drain_results();
      roll = $urandom_range(0, 99);
      h    = $urandom_range(1, 10);
      iv   = $urandom_range(1, 6);
      cnt  = $urandom_range(0, 4);
      if ($urandom_range(0, 9) == 0) h = $urandom;
      if ($urandom_range(0, 9) == 0) iv = $urandom;
      if ($urandom_range(0, 9) == 0) cnt = $urandom_range(0, 65535);
      if (roll < 38) begin
        op = OP_TICK;
      end else if (roll < 72) begin
        op = OP_START;
      end else if (roll < 88) begin
        op = OP_CANCEL;
      end else if (roll < 91) begin
        op = OP_CLEAR;
      end else if (roll < 95) begin
        op = OP_START;
        if ($urandom_range(0, 1) == 0) h = 32'd0;
        else iv = 32'd0;
      end else begin
        op  = op_t'($urandom_range(0, 3));
        h   = $urandom;
        iv  = $urandom;
        cnt = $urandom_range(0, 65535);
      end
      issue_command(op, h, iv, cnt, 1'b0, KIND_OK, 32'd0);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("tb_sorted_timer_queue: PASS");
    end else begin
      $display("tb_sorted_timer_queue: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sto_pkg.sv
rtl/sto_cell.sv
rtl/sto_chain.sv
rtl/sorted_timer_queue.sv
test/tb_sorted_timer_queue.sv
